// ===== sv/hid_frame_reassembler_macros.svh =====
// Assertion macros for the reassembler top-level RTL.
`ifndef HID_FRAME_REASSEMBLER_MACROS_SVH
`define HID_FRAME_REASSEMBLER_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define HFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define HFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hfr_pkg.sv =====
package hfr_pkg;

  // Packet and protocol constants
  localparam int          PACKET_BYTES_DEF = 64;
  localparam int          HEADER_END       = 8;
  localparam logic [7:0]  SYNC_BYTE        = 8'h23;
  localparam logic [15:0] ID_RESET         = 16'hFFFF;
  localparam logic [6:0]  MIN_LEN_RESET    = 7'd9;
  localparam logic [7:0]  MARKER_RESET     = 8'h3F;

  // Configuration register map
  localparam int APB_ADDR_W = 3;
  localparam logic REG_MIN_PACKET_LEN = 1'b0;
  localparam logic REG_REPORT_MARKER  = 1'b1;

  // Result queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_CONTENT    = 2'd0,
    KIND_RUNT       = 2'd1,
    KIND_BAD_MARKER = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [6:0] packet_len;
    logic       first_of_packet;
    logic       last_of_packet;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  content_byte;
    logic [15:0] message_id;
    logic [31:0] message_len;
    logic [31:0] byte_offset;
    logic        starts_message;
    logic        past_length;
    logic        ends_message;
  } out_word_t;

  // One queued result before the length flags are worked out
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  content_byte;
    logic [15:0] message_id;
    logic [31:0] message_len;
    logic [31:0] byte_offset;
    logic        starts_message;
    logic        last_of_packet;
  } q_entry_t;

  // Up to two results pushed by one input word
  typedef struct packed {
    logic [1:0] num;
    q_entry_t   e0;
    q_entry_t   e1;
  } q_push_t;

  function automatic q_entry_t mk_entry(kind_t k, logic [7:0] b, logic [15:0] id,
                                        logic [31:0] len, logic [31:0] off,
                                        logic s, logic l);
    q_entry_t e;
    e.kind           = k;
    e.content_byte   = b;
    e.message_id     = id;
    e.message_len    = len;
    e.byte_offset    = off;
    e.starts_message = s;
    e.last_of_packet = l;
    return e;
  endfunction

endpackage

// ===== sv/hfr_front.sv =====
module hfr_front #(
  parameter int PACKET_BYTES = hfr_pkg::PACKET_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  hfr_pkg::in_word_t item,
  input  logic [6:0]       min_packet_len,
  input  logic [7:0]       report_marker,
  output hfr_pkg::q_push_t push
);
  import hfr_pkg::*;

  localparam int IDX_W = $clog2(PACKET_BYTES + 1);

  typedef enum logic [1:0] {MODE_IDLE, MODE_START, MODE_HEADER, MODE_CONT} mode_t;

  mode_t              mode, mode_next;
  logic [IDX_W-1:0]   packet_index, packet_index_next;
  logic [7:0]         held_byte, held_byte_next;
  logic [47:0]        header_shift, header_shift_next;
  logic               frame_open, frame_open_next;
  logic [15:0]        open_id, open_id_next;
  logic [31:0]        open_len, open_len_next;
  logic [31:0]        content_count, content_count_next;

  logic [31:0] count_p1, count_p2;
  logic [47:0] shifted;

  assign count_p1 = content_count + 32'd1;
  assign count_p2 = content_count + 32'd2;
  assign shifted  = {header_shift[39:0], item.data_byte};

  // Parse one packet byte and classify it
  always_comb begin
    mode_next          = mode;
    packet_index_next  = packet_index;
    held_byte_next     = held_byte;
    header_shift_next  = header_shift;
    frame_open_next    = frame_open;
    open_id_next       = open_id;
    open_len_next      = open_len;
    content_count_next = content_count;
    push               = '0;

    if (accept) begin
      if (item.first_of_packet) begin
        // Start a packet: abandon any unfinished one, check length and marker
        frame_open_next   = content_count < open_len;
        packet_index_next = IDX_W'(1);
        header_shift_next = '0;
        held_byte_next    = '0;
        mode_next         = MODE_IDLE;
        if (item.packet_len < min_packet_len) begin
          push.num = 2'd1;
          push.e0  = mk_entry(KIND_RUNT, 8'd0, open_id, open_len, content_count,
                              1'b0, 1'b0);
        end else if (item.data_byte != report_marker) begin
          push.num = 2'd1;
          push.e0  = mk_entry(KIND_BAD_MARKER, 8'd0, open_id, open_len, content_count,
                              1'b0, 1'b0);
        end else if (!item.last_of_packet) begin
          mode_next = MODE_START;
        end
      end else if (mode != MODE_IDLE) begin
        if (packet_index < IDX_W'(PACKET_BYTES)) begin
          packet_index_next = packet_index + IDX_W'(1);
          unique case (mode)
            MODE_START: begin
              if (packet_index == IDX_W'(1)) begin
                // Hold a possible first sync byte while no message is open
                if (!frame_open && item.data_byte == SYNC_BYTE && !item.last_of_packet) begin
                  held_byte_next = item.data_byte;
                end else begin
                  push.num           = 2'd1;
                  push.e0            = mk_entry(KIND_CONTENT, item.data_byte, open_id,
                                                open_len, content_count, 1'b0,
                                                item.last_of_packet);
                  content_count_next = count_p1;
                  mode_next          = MODE_CONT;
                end
              end else if (item.data_byte == SYNC_BYTE) begin
                mode_next = MODE_HEADER;
              end else begin
                // Not a header: release the held byte ahead of this one
                push.num           = 2'd2;
                push.e0            = mk_entry(KIND_CONTENT, held_byte, open_id, open_len,
                                              content_count, 1'b0, 1'b0);
                push.e1            = mk_entry(KIND_CONTENT, item.data_byte, open_id,
                                              open_len, count_p1, 1'b0,
                                              item.last_of_packet);
                content_count_next = count_p2;
                mode_next          = MODE_CONT;
              end
            end
            MODE_HEADER: begin
              if (packet_index <= IDX_W'(HEADER_END)) begin
                // Shift in id and length, load them on the last header byte
                header_shift_next = shifted;
                if (packet_index == IDX_W'(HEADER_END)) begin
                  open_id_next       = shifted[47:32];
                  open_len_next      = shifted[31:0];
                  content_count_next = '0;
                end
              end else begin
                push.num           = 2'd1;
                push.e0            = mk_entry(KIND_CONTENT, item.data_byte, open_id,
                                              open_len, content_count,
                                              packet_index == IDX_W'(HEADER_END + 1),
                                              item.last_of_packet);
                content_count_next = count_p1;
              end
            end
            MODE_CONT: begin
              push.num           = 2'd1;
              push.e0            = mk_entry(KIND_CONTENT, item.data_byte, open_id,
                                            open_len, content_count, 1'b0,
                                            item.last_of_packet);
              content_count_next = count_p1;
            end
            MODE_IDLE: begin
              mode_next = MODE_IDLE;
            end
          endcase
        end
        if (item.last_of_packet) begin
          mode_next = MODE_IDLE;
        end
      end
    end
  end

  // Hold parser and message state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      packet_index  <= '0;
      held_byte     <= '0;
      header_shift  <= '0;
      frame_open    <= 1'b0;
      open_id       <= ID_RESET;
      open_len      <= '0;
      content_count <= '0;
    end else begin
      mode          <= mode_next;
      packet_index  <= packet_index_next;
      held_byte     <= held_byte_next;
      header_shift  <= header_shift_next;
      frame_open    <= frame_open_next;
      open_id       <= open_id_next;
      open_len      <= open_len_next;
      content_count <= content_count_next;
    end
  end

endmodule

// ===== sv/hfr_queue.sv =====
module hfr_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  hfr_pkg::q_push_t                   push,
  input  logic                               pop,
  output hfr_pkg::q_entry_t                  head,
  output logic                               empty,
  output logic [hfr_pkg::QUEUE_CNT_W-1:0]    level
);
  import hfr_pkg::*;

  q_entry_t               mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr + QUEUE_PTR_W'(1);
  assign head      = mem[rd_ptr];
  assign empty     = level == '0;

  // Store up to two words per cycle
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.e0;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr_p1] <= push.e1;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_W'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      level <= level + QUEUE_CNT_W'(push.num) - QUEUE_CNT_W'(pop);
    end
  end

endmodule

// ===== sv/hfr_back.sv =====
module hfr_back (
  input  logic               clk,
  input  logic               rst,
  input  hfr_pkg::q_entry_t  head,
  input  logic               empty,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output hfr_pkg::out_word_t result
);
  import hfr_pkg::*;

  out_word_t   word;
  logic [31:0] next_off;
  logic        is_content;

  assign pop = !empty && (!result_valid || !result_stall);

  // Work out the length flags for the word at the queue head
  always_comb begin
    next_off            = head.byte_offset + 32'd1;
    is_content          = head.kind == KIND_CONTENT;
    word.kind           = head.kind;
    word.content_byte   = head.content_byte;
    word.message_id     = head.message_id;
    word.message_len    = head.message_len;
    word.byte_offset    = head.byte_offset;
    word.starts_message = head.starts_message;
    word.past_length    = is_content && (head.byte_offset >= head.message_len);
    word.ends_message   = is_content && head.last_of_packet &&
                          (next_off >= head.message_len);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= word;
    end
  end

endmodule

// ===== sv/hid_frame_reassembler.sv =====
// Path: each result is written to the result queue when its input word is accepted,
// then to the output register; a second result from the same word follows the first.
// Throughput: one input word per cycle unless item_stall holds it; the output register
// drains one result per cycle unless result_stall holds it.
// A four-entry result queue sets how far input runs ahead of a stalled output.
// Reset: synchronous rst resets parser state, message state, queue and
// configuration registers (min_packet_len 9, report_marker 63).
`include "hid_frame_reassembler_macros.svh"

module hid_frame_reassembler #(
  parameter int PACKET_BYTES = hfr_pkg::PACKET_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  hfr_pkg::in_word_t               item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output hfr_pkg::out_word_t              result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hfr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import hfr_pkg::*;

  logic                   accept;
  logic                   cfg_write;
  logic [6:0]             min_packet_len;
  logic [7:0]             report_marker;
  q_push_t                push;
  q_entry_t               head;
  logic                   q_empty;
  logic                   pop;
  logic [QUEUE_CNT_W-1:0] q_level;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_packet_len <= MIN_LEN_RESET;
      report_marker  <= MARKER_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_MIN_PACKET_LEN: min_packet_len <= pwdata[6:0];
        REG_REPORT_MARKER:  report_marker  <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_PACKET_LEN: prdata = {25'd0, min_packet_len};
      REG_REPORT_MARKER:  prdata = {24'd0, report_marker};
    endcase
  end

  // Stall input while the queue lacks room for two words
  assign item_stall = q_level > QUEUE_CNT_W'(QUEUE_DEPTH - 2);
  assign accept     = item_valid && !item_stall;

  hfr_front #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (item),
    .min_packet_len (min_packet_len),
    .report_marker  (report_marker),
    .push           (push)
  );

  hfr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (q_empty),
    .level (q_level)
  );

  hfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `HFR_ASSERT_IMP(a_no_overflow, push.num != 2'd0, q_level + push.num <= QUEUE_DEPTH, "result queue overflow")
  `HFR_ASSERT_IMP(a_push_on_accept, push.num != 2'd0, accept, "result pushed without an accepted word")
  `HFR_ASSERT_IMP(a_status_clean, result_valid && result.kind != KIND_CONTENT, !result.past_length && !result.ends_message && !result.starts_message && result.content_byte == 8'd0, "status result carries content flags")
  `HFR_ASSERT_NXT(a_pop_fills_output, pop, result_valid, "popped word not presented")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import hfr_pkg::*;

  // Parser modes of the local reassembly model
  typedef enum logic [1:0] {
    PM_IDLE,
    PM_START,
    PM_HEADER,
    PM_CONT
  } parse_mode_t;

  // One directed row; pinned rows carry a hand-typed expectation
  typedef struct {
    in_word_t  w;
    bit        pinned;
    bit        has_res;
    out_word_t res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  in_word_t              item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_word_t             result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Register shadows and message state of the model
  logic [6:0]  min_len_q;
  logic [7:0]  marker_q;
  logic        msg_open;
  logic [15:0] msg_id;
  logic [31:0] msg_len;
  logic [31:0] byte_count;
  int          pkt_pos;
  parse_mode_t pmode;
  logic [7:0]  held_sync;
  logic [47:0] hdr_bits;

  out_word_t word_results[$];
  out_word_t pending_results[$];
  stim_row_t stim_rows[$];
  int        err_count = 0;
  int        words_sent = 0;
  int        results_seen = 0;
  int        idle_pct = 35;

  hid_frame_reassembler dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    err_count++;
    if (err_count <= 60) begin
      $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  // Return the model to its post-reset state
  task automatic reset_model();
    min_len_q  = MIN_LEN_RESET;
    marker_q   = MARKER_RESET;
    msg_open   = 1'b0;
    msg_id     = ID_RESET;
    msg_len    = '0;
    byte_count = '0;
    pkt_pos    = 0;
    pmode      = PM_IDLE;
    held_sync  = '0;
    hdr_bits   = '0;
  endtask

  task automatic emit_status(input kind_t k);
    out_word_t r;
    r.kind           = k;
    r.content_byte   = '0;
    r.message_id     = msg_id;
    r.message_len    = msg_len;
    r.byte_offset    = byte_count;
    r.starts_message = 1'b0;
    r.past_length    = 1'b0;
    r.ends_message   = 1'b0;
    word_results.push_back(r);
  endtask

  // Emit one content byte and advance the content count
  task automatic emit_content(input logic [7:0] b, input logic starts, input logic ends_pkt);
    out_word_t   r;
    logic [31:0] nxt;
    nxt              = byte_count + 32'd1;
    r.kind           = KIND_CONTENT;
    r.content_byte   = b;
    r.message_id     = msg_id;
    r.message_len    = msg_len;
    r.byte_offset    = byte_count;
    r.starts_message = starts;
    r.past_length    = (byte_count >= msg_len);
    r.ends_message   = ends_pkt && (nxt >= msg_len);
    word_results.push_back(r);
    byte_count = nxt;
  endtask

  // Work out the results that one accepted word causes
  task automatic reassemble_word(input in_word_t w);
    word_results.delete();
    if (w.first_of_packet) begin
      msg_open  = (byte_count < msg_len);
      pkt_pos   = 1;
      hdr_bits  = '0;
      held_sync = '0;
      pmode     = PM_IDLE;
      if (w.packet_len < min_len_q) begin
        emit_status(KIND_RUNT);
      end else if (w.data_byte != marker_q) begin
        emit_status(KIND_BAD_MARKER);
      end else if (!w.last_of_packet) begin
        pmode = PM_START;
      end
    end else if (pmode != PM_IDLE) begin
      if (pkt_pos < PACKET_BYTES_DEF) begin
        case (pmode)
          PM_START: begin
            if (pkt_pos == 1) begin
              // hold a possible first sync byte while no message is open
              if (!msg_open && w.data_byte == SYNC_BYTE && !w.last_of_packet) begin
                held_sync = w.data_byte;
              end else begin
                emit_content(w.data_byte, 1'b0, w.last_of_packet);
                pmode = PM_CONT;
              end
            end else if (w.data_byte == SYNC_BYTE) begin
              pmode = PM_HEADER;
            end else begin
              emit_content(held_sync, 1'b0, 1'b0);
              emit_content(w.data_byte, 1'b0, w.last_of_packet);
              pmode = PM_CONT;
            end
          end
          PM_HEADER: begin
            if (pkt_pos <= HEADER_END) begin
              hdr_bits = {hdr_bits[39:0], w.data_byte};
              if (pkt_pos == HEADER_END) begin
                msg_id     = hdr_bits[47:32];
                msg_len    = hdr_bits[31:0];
                byte_count = '0;
              end
            end else begin
              emit_content(w.data_byte, pkt_pos == HEADER_END + 1, w.last_of_packet);
            end
          end
          default: begin
            emit_content(w.data_byte, 1'b0, w.last_of_packet);
          end
        endcase
        pkt_pos++;
      end
      if (w.last_of_packet) pmode = PM_IDLE;
    end
  endtask

  // Present one word and hold it until accepted
  task automatic drive_word(input in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    words_sent++;
  endtask

  task automatic send_word(input in_word_t w);
    reassemble_word(w);
    foreach (word_results[i]) pending_results.push_back(word_results[i]);
    drive_word(w);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic [6:0] plen, input bit is_first,
                           input bit is_last);
    in_word_t w;
    w.data_byte       = d;
    w.packet_len      = plen;
    w.first_of_packet = is_first;
    w.last_of_packet  = is_last;
    send_word(w);
  endtask

  // Drop valid, wait for every expected word, then let in-flight words settle
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write a register, then read it back
  task automatic write_register(input logic reg_sel, input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_MIN_PACKET_LEN) begin
      min_len_q = value[6:0];
      readback  = {25'd0, value[6:0]};
    end else begin
      marker_q = value[7:0];
      readback = {24'd0, value[7:0]};
    end
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== readback) begin
      flag_mismatch($sformatf("register %0d read %h, wrote %h", reg_sel, prdata, readback));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] d, input logic [6:0] plen, input bit is_first,
                         input bit is_last);
    stim_row_t row;
    row.w.data_byte       = d;
    row.w.packet_len      = plen;
    row.w.first_of_packet = is_first;
    row.w.last_of_packet  = is_last;
    row.pinned            = 1'b0;
    row.has_res           = 1'b0;
    row.res               = '0;
    stim_rows.push_back(row);
  endtask

  // Pinned rows only stand before the first header, so id and length are at reset
  task automatic add_pinned(input logic [7:0] d, input logic [6:0] plen, input bit is_first,
                            input bit is_last, input bit has_res, input kind_t k);
    stim_row_t row;
    add_row(d, plen, is_first, is_last);
    row                    = stim_rows.pop_back();
    row.pinned             = 1'b1;
    row.has_res            = has_res;
    row.res.kind           = k;
    row.res.content_byte   = '0;
    row.res.message_id     = ID_RESET;
    row.res.message_len    = '0;
    row.res.byte_offset    = '0;
    row.res.starts_message = 1'b0;
    row.res.past_length    = 1'b0;
    row.res.ends_message   = 1'b0;
    stim_rows.push_back(row);
  endtask

  // One random packet: mostly well-formed headers and continuations
  task automatic send_random_packet();
    int          n;
    int          plen;
    int          pick;
    int          strays;
    bit          header;
    bit          no_end;
    logic [7:0]  b;
    logic [31:0] mlen;
    logic [47:0] hdr48;
    pick = $urandom_range(99);
    if (pick < 70) n = $urandom_range(1, 24);
    else if (pick < 92) n = $urandom_range(25, 64);
    else n = $urandom_range(65, 70);
    if ($urandom_range(99) < 85) plen = $urandom_range(int'(min_len_q), 64);
    else plen = $urandom_range(0, 64);
    header = !(byte_count < msg_len) && ($urandom_range(99) < 75);
    if (header && n < 9 && $urandom_range(99) < 80) n += 9;
    pick = $urandom_range(99);
    if (pick < 60) mlen = $urandom_range(0, 40);
    else if (pick < 80) mlen = $urandom_range(41, 200);
    else if (pick < 90) mlen = 32'hFFFF_FFFF;
    else mlen = $urandom;
    hdr48  = {16'($urandom), mlen};
    no_end = ($urandom_range(99) < 5);
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        b = ($urandom_range(99) < 88) ? marker_q : 8'($urandom_range(255));
      end else if (header && i <= 2) begin
        b = SYNC_BYTE;
      end else if (header && i <= HEADER_END) begin
        b = hdr48[8 * (HEADER_END - i) +: 8];
      end else begin
        b = ($urandom_range(99) < 10) ? SYNC_BYTE : 8'($urandom_range(255));
      end
      send_byte(b, 7'(plen), i == 0, (i == n - 1) && !no_end);
    end
    // stray words between packets
    if ($urandom_range(99) < 6) begin
      strays = $urandom_range(1, 3);
      repeat (strays) send_byte(8'($urandom_range(255)), 7'($urandom_range(0, 64)), 1'b0,
                                1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(input int budget);
    int start_count;
    start_count = words_sent;
    while (words_sent - start_count < budget) send_random_packet();
  endtask

  task automatic compare_result(input out_word_t got, input out_word_t exp_w);
    string tag;
    tag = $sformatf("result %0d", results_seen);
    if (got.kind !== exp_w.kind)
      flag_mismatch($sformatf("%s kind %0d exp %0d", tag, got.kind, exp_w.kind));
    if (got.content_byte !== exp_w.content_byte)
      flag_mismatch($sformatf("%s content_byte %h exp %h", tag, got.content_byte,
                              exp_w.content_byte));
    if (got.message_id !== exp_w.message_id)
      flag_mismatch($sformatf("%s message_id %h exp %h", tag, got.message_id,
                              exp_w.message_id));
    if (got.message_len !== exp_w.message_len)
      flag_mismatch($sformatf("%s message_len %h exp %h", tag, got.message_len,
                              exp_w.message_len));
    if (got.byte_offset !== exp_w.byte_offset)
      flag_mismatch($sformatf("%s byte_offset %h exp %h", tag, got.byte_offset,
                              exp_w.byte_offset));
    if (got.starts_message !== exp_w.starts_message)
      flag_mismatch($sformatf("%s starts_message %b exp %b", tag, got.starts_message,
                              exp_w.starts_message));
    if (got.past_length !== exp_w.past_length)
      flag_mismatch($sformatf("%s past_length %b exp %b", tag, got.past_length,
                              exp_w.past_length));
    if (got.ends_message !== exp_w.ends_message)
      flag_mismatch($sformatf("%s ends_message %b exp %b", tag, got.ends_message,
                              exp_w.ends_message));
  endtask

  // Randomly stall the result side
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < idle_pct);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result %0d with nothing pending", results_seen));
      end else begin
        compare_result(result, pending_results.pop_front());
      end
      results_seen++;
    end
  end

  initial begin
    reset_model();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // runt, bad marker, stray word, single-byte packet
    add_pinned(8'h00, 7'd0, 1'b1, 1'b0, 1'b1, KIND_RUNT);
    add_pinned(8'hFF, 7'd64, 1'b1, 1'b1, 1'b1, KIND_BAD_MARKER);
    add_pinned(8'hAA, 7'd0, 1'b0, 1'b0, 1'b0, KIND_CONTENT);
    add_pinned(MARKER_RESET, 7'd9, 1'b1, 1'b1, 1'b0, KIND_CONTENT);
    // header packet: id 1234, length 3, four content bytes so the last is padding
    add_row(MARKER_RESET, 7'd64, 1'b1, 1'b0);
    add_row(SYNC_BYTE, 7'd64, 1'b0, 1'b0);
    add_row(SYNC_BYTE, 7'd64, 1'b0, 1'b0);
    add_row(8'h12, 7'd64, 1'b0, 1'b0);
    add_row(8'h34, 7'd64, 1'b0, 1'b0);
    add_row(8'h00, 7'd64, 1'b0, 1'b0);
    add_row(8'h00, 7'd64, 1'b0, 1'b0);
    add_row(8'h00, 7'd64, 1'b0, 1'b0);
    add_row(8'h03, 7'd64, 1'b0, 1'b0);
    add_row(8'h00, 7'd64, 1'b0, 1'b0);
    add_row(8'hFF, 7'd64, 1'b0, 1'b0);
    add_row(8'h55, 7'd64, 1'b0, 1'b0);
    add_row(8'hAA, 7'd64, 1'b0, 1'b1);
    // held sync byte flushed together with the next byte
    add_row(MARKER_RESET, 7'd9, 1'b1, 1'b0);
    add_row(SYNC_BYTE, 7'd9, 1'b0, 1'b0);
    add_row(8'h41, 7'd9, 1'b0, 1'b1);
    // sync byte that ends its packet goes out at once
    add_row(MARKER_RESET, 7'd9, 1'b1, 1'b0);
    add_row(SYNC_BYTE, 7'd9, 1'b0, 1'b1);
    // truncated header changes nothing
    add_row(MARKER_RESET, 7'd9, 1'b1, 1'b0);
    add_row(SYNC_BYTE, 7'd9, 1'b0, 1'b0);
    add_row(SYNC_BYTE, 7'd9, 1'b0, 1'b0);
    add_row(8'h7F, 7'd9, 1'b0, 1'b1);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].pinned) begin
        reassemble_word(stim_rows[i].w);
        if (stim_rows[i].has_res) pending_results.push_back(stim_rows[i].res);
        drive_word(stim_rows[i].w);
      end else begin
        send_word(stim_rows[i].w);
      end
    end

    // random phases, one per register setting
    run_phase(380);
    settle();
    write_register(REG_MIN_PACKET_LEN, 32'd64);
    write_register(REG_REPORT_MARKER, 32'h00);
    run_phase(380);
    settle();
    write_register(REG_MIN_PACKET_LEN, 32'd9);
    write_register(REG_REPORT_MARKER, 32'hFF);
    run_phase(380);
    settle();
    idle_pct = 0;
    write_register(REG_MIN_PACKET_LEN, $urandom_range(9, 64));
    write_register(REG_REPORT_MARKER, $urandom_range(255));
    run_phase(380);
    settle();
    idle_pct = 35;
    write_register(REG_MIN_PACKET_LEN, 32'(MIN_LEN_RESET));
    write_register(REG_REPORT_MARKER, 32'(MARKER_RESET));
    run_phase(380);
    settle();

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
